@@ hdl/pol_pkg.sv @@
// ============================================================================
// pol_pkg
// Shared types and codes for the partition offset locator: request kinds,
// status codes, register indexes and the result beat layout.
// ============================================================================
package pol_pkg;

    // field widths of the stream beats
    localparam int REQ_W      = 3;
    localparam int VAL_W      = 32;
    localparam int ST_W       = 2;
    localparam int PART_W     = 8;
    localparam int RANGE_W    = 32;
    localparam int USIZE_W    = 16;
    localparam int PROD_W     = VAL_W + USIZE_W;
    localparam int OUT_TDATA_W = 112;

    // configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_OFFSET  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_UNIFORM_SIZE = 1'd1;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FILL   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_LOCATE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BELOW  = 2'd1;
    localparam logic [ST_W-1:0] ST_BEYOND = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

    // one result beat, status in the lowest bits
    typedef struct packed {
        logic [RANGE_W-1:0] coefficient_count;
        logic [RANGE_W-1:0] range_end;
        logic [RANGE_W-1:0] range_start;
        logic [PART_W-1:0]  partition_number;
        logic [ST_W-1:0]    status;
    } t_result;

endpackage

@@ hdl/partition_offset_locator.sv @@
// ============================================================================
// partition_offset_locator
// Sorted table of partition start offsets built as running sums, with
// clear, append, uniform fill, upper-bound locate and range query requests.
// ============================================================================
//
//  channel    | dir | beat contents
//  -----------+-----+---------------------------------------------------------
//  s_axis     | in  | tuser: req_type; tdata: value
//  m_axis     | out | tdata: status, partition_number, range_start, range_end,
//             |     |        coefficient_count
//  i_cfg      | in  | index 0 base_offset, index 1 uniform_size
//
//  clear, append and unknown requests are accepted, then their result is sent.
//  range query makes two reads of the offset memory, one port.
//  locate runs S = ceil(log2(count+1)) search steps when in range; each
//  step is one read of the offset memory plus a compare.
//  uniform fill makes one memory write per new partition.
//  one item at a time; a stalled result beat holds the next result back.
//  reset is synchronous; the offset memory needs no clearing pass.
//
module partition_offset_locator #(
    parameter int MAX_PARTITIONS = 256,
    parameter int INDEX_BITS     = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [pol_pkg::VAL_W-1:0]            s_axis_tdata,  // [31:0] value
    input  logic [pol_pkg::REQ_W-1:0]            s_axis_tuser,  // [2:0] req_type
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [1:0] status, [9:2] partition_number, [41:10] range_start,
    // [73:42] range_end, [105:74] coefficient_count, [111:106] zero
    output logic [pol_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // configuration writes
    input  logic                                 i_cfg_we,
    input  logic [pol_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [pol_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);

    localparam int AW    = $clog2(MAX_PARTITIONS + 1);
    localparam int DEPTH = MAX_PARTITIONS + 1;
    localparam int CW    = ((INDEX_BITS > pol_pkg::PROD_W) ? INDEX_BITS : pol_pkg::PROD_W) + 1;
    localparam int PAD_W = pol_pkg::OUT_TDATA_W - $bits(pol_pkg::t_result);

    // state codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RESP = 4'd1;
    localparam logic [3:0] S_FMUL = 4'd2;
    localparam logic [3:0] S_FCHK = 4'd3;
    localparam logic [3:0] S_FILL = 4'd4;
    localparam logic [3:0] S_SRD  = 4'd5;
    localparam logic [3:0] S_SCMP = 4'd6;
    localparam logic [3:0] S_Q1   = 4'd7;
    localparam logic [3:0] S_Q2   = 4'd8;

    // offset memory
    logic [INDEX_BITS-1:0] r_mem [DEPTH];
    logic [INDEX_BITS-1:0] r_rd_data;
    logic                  r_rd_zero;

    logic [3:0]                    r_state, n_state;
    logic [pol_pkg::CFG_DATA_W-1:0] r_base;
    logic [pol_pkg::USIZE_W-1:0]   r_usize;
    logic [AW-1:0]                 r_count, n_count;
    logic [INDEX_BITS-1:0]         r_run, n_run;
    logic [INDEX_BITS-1:0]         r_first, n_first;
    logic [pol_pkg::VAL_W-1:0]     r_val, n_val;
    logic [pol_pkg::PROD_W-1:0]    r_total, n_total;
    logic [AW-1:0]                 r_left, n_left;
    logic [AW-1:0]                 r_lo, n_lo;
    logic [AW-1:0]                 r_hi, n_hi;
    logic [AW-1:0]                 r_mid, n_mid;
    logic [INDEX_BITS-1:0]         r_start, n_start;
    logic [INDEX_BITS-1:0]         r_end, n_end;
    pol_pkg::t_result              r_res, n_res;
    pol_pkg::t_result              r_mdata, n_mdata;
    logic                          r_mv, n_mv;

    logic                  in_fire;
    logic                  out_free;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [INDEX_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [INDEX_BITS-1:0] rd_val;
    logic [CW-1:0]         app_sum;
    logic [CW-1:0]         fill_sum;
    logic [INDEX_BITS-1:0] step_run;
    logic [AW-1:0]         mid_calc;
    logic                  room_short;

    // handshake
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_mv || m_axis_tready;
    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = {PAD_W'(0), r_mdata};

    // entry zero is shadowed in a register so a never-cleared table reads zero
    assign rd_val   = r_rd_zero ? r_first : r_rd_data;
    assign app_sum  = CW'(r_run) + CW'(s_axis_tdata);
    assign fill_sum = CW'(r_run) + CW'(r_total);
    assign step_run = r_run + INDEX_BITS'(r_usize);
    assign mid_calc = r_lo + ((r_hi - r_lo) >> 1);
    assign room_short = {1'b0, r_val} >
                        (33'(MAX_PARTITIONS) - 33'(r_count));

    // request sequencer
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_run    = r_run;
        n_first  = r_first;
        n_val    = r_val;
        n_total  = r_total;
        n_left   = r_left;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_start  = r_start;
        n_end    = r_end;
        n_res    = r_res;
        n_mdata  = r_mdata;
        n_mv     = r_mv && !m_axis_tready;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_val        = s_axis_tdata;
                    n_res        = '0;
                    n_res.status = pol_pkg::ST_OK;
                    n_state      = S_RESP;
                    case (s_axis_tuser)
                        pol_pkg::REQ_CLEAR: begin
                            n_count   = '0;
                            n_run     = INDEX_BITS'(r_base);
                            n_first   = INDEX_BITS'(r_base);
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            mem_wdata = INDEX_BITS'(r_base);
                        end
                        pol_pkg::REQ_APPEND: begin
                            if (32'(r_count) >= 32'(MAX_PARTITIONS) ||
                                (|app_sum[CW-1:INDEX_BITS])) begin
                                n_res.status = pol_pkg::ST_FULL;
                            end else begin
                                n_run     = app_sum[INDEX_BITS-1:0];
                                n_count   = r_count + AW'(1);
                                mem_we    = 1'b1;
                                mem_waddr = r_count + AW'(1);
                                mem_wdata = app_sum[INDEX_BITS-1:0];
                            end
                        end
                        pol_pkg::REQ_FILL: begin
                            n_state = S_FMUL;
                        end
                        pol_pkg::REQ_LOCATE: begin
                            if (CW'(s_axis_tdata) < CW'(r_first)) begin
                                n_res.status = pol_pkg::ST_BELOW;
                            end else if (CW'(s_axis_tdata) >= CW'(r_run)) begin
                                n_res.status = pol_pkg::ST_BEYOND;
                            end else begin
                                n_lo    = '0;
                                n_hi    = r_count;
                                n_end   = r_run;
                                n_state = S_SRD;
                            end
                        end
                        pol_pkg::REQ_QUERY: begin
                            if (s_axis_tdata >= 32'(r_count)) begin
                                n_res.status = pol_pkg::ST_BEYOND;
                            end else begin
                                n_mid     = AW'(s_axis_tdata);
                                mem_re    = 1'b1;
                                mem_raddr = AW'(s_axis_tdata);
                                n_state   = S_Q1;
                            end
                        end
                        default: begin
                            n_res.status = pol_pkg::ST_BEYOND;
                        end
                    endcase
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_mv    = 1'b1;
                    n_mdata = r_res;
                    n_state = S_IDLE;
                end
            end
            // product of count and size, registered before the bound check
            S_FMUL: begin
                n_total = r_val * r_usize;
                n_state = S_FCHK;
            end
            S_FCHK: begin
                if (room_short || (|fill_sum[CW-1:INDEX_BITS])) begin
                    n_res.status = pol_pkg::ST_FULL;
                    n_state      = S_RESP;
                end else if (r_val == '0) begin
                    n_state = S_RESP;
                end else begin
                    n_left  = AW'(r_val);
                    n_state = S_FILL;
                end
            end
            // one new partition end per cycle
            S_FILL: begin
                n_run     = step_run;
                n_count   = r_count + AW'(1);
                mem_we    = 1'b1;
                mem_waddr = r_count + AW'(1);
                mem_wdata = step_run;
                n_left    = r_left - AW'(1);
                if (r_left == AW'(1)) begin
                    n_state = S_RESP;
                end
            end
            // upper-bound search: read the middle entry
            S_SRD: begin
                if (r_lo < r_hi) begin
                    n_mid     = mid_calc;
                    mem_re    = 1'b1;
                    mem_raddr = mid_calc;
                    n_state   = S_SCMP;
                end else begin
                    n_res.status            = pol_pkg::ST_OK;
                    n_res.partition_number  = 8'(r_lo - AW'(1));
                    n_res.range_start       = 32'(r_start);
                    n_res.range_end         = 32'(r_end);
                    n_res.coefficient_count = 32'(r_end) - 32'(r_start);
                    n_state                 = S_RESP;
                end
            end
            // narrow the window, keeping the bounding offsets
            S_SCMP: begin
                if (CW'(rd_val) > CW'(r_val)) begin
                    n_hi  = r_mid;
                    n_end = rd_val;
                end else begin
                    n_lo    = r_mid + AW'(1);
                    n_start = rd_val;
                end
                n_state = S_SRD;
            end
            // range query: start, then end of the partition
            S_Q1: begin
                n_start   = rd_val;
                mem_re    = 1'b1;
                mem_raddr = r_mid + AW'(1);
                n_state   = S_Q2;
            end
            S_Q2: begin
                n_res.status            = pol_pkg::ST_OK;
                n_res.partition_number  = 8'(r_mid);
                n_res.range_start       = 32'(r_start);
                n_res.range_end         = 32'(rd_val);
                n_res.coefficient_count = 32'(rd_val) - 32'(r_start);
                n_end                   = rd_val;
                n_state                 = S_RESP;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_run   <= '0;
            r_first <= '0;
            r_mv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_run   <= n_run;
            r_first <= n_first;
            r_mv    <= n_mv;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_usize <= pol_pkg::USIZE_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                pol_pkg::REG_BASE_OFFSET:  r_base  <= i_cfg_wdata;
                pol_pkg::REG_UNIFORM_SIZE: r_usize <= i_cfg_wdata[pol_pkg::USIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_total <= n_total;
        r_left  <= n_left;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_start <= n_start;
        r_end   <= n_end;
        r_res   <= n_res;
        r_mdata <= n_mdata;
    end

    // offset memory; reads and writes never fall in the same request
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
            r_rd_zero <= (mem_raddr == '0);
        end
    end

`ifndef NO_ASSERTIONS
    // table never holds more partitions than it has room for
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(MAX_PARTITIONS))
        else $error("partition count beyond table size");

    // search window stays ordered
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRD || r_state == S_SCMP) |-> (r_lo <= r_hi))
        else $error("search window inverted");

    // fill loop never runs with nothing left to write
    a_fill_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_left != '0))
        else $error("fill loop with zero remaining");

    // an accepted request always leaves idle to produce its result
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE))
        else $error("accepted request dropped");

    // memory is never read and written in the same cycle
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("offset memory read and write overlap");
`endif

endmodule
